>>> src/ccsf_pkg.sv
// Shared constants and types for the character canvas shape fill block.
package ccsf_pkg;

  // Default canvas storage size in columns and rows.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Width of a size register and of a canvas row or column number.
  localparam int DIM_W   = 7;
  // Signed working width for shape coordinates, which may fall far off the canvas.
  localparam int COORD_W = 11;
  // Width of the shape row counter; a diamond spans up to 2*127+1 rows.
  localparam int ROWK_W  = 9;

  // Size register reset value.
  localparam logic [DIM_W-1:0] SIZE_RESET = 7'd64;

  // Character codes.
  localparam logic [7:0] CHAR_BLANK = 8'd46;  // '.'
  localparam logic [7:0] CHAR_SPACE = 8'd32;  // ' '
  localparam logic [7:0] CHAR_ZERO  = 8'd48;  // '0'

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_PIXEL = 3'd0,
    CMD_RECT  = 3'd1,
    CMD_UP    = 3'd2,
    CMD_DOWN  = 3'd3,
    CMD_DIAM  = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_READ  = 3'd6
  } cmd_t;

endpackage

>>> src/ccsf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ccsf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/char_canvas_shape_fill.sv
// Character canvas: one RAM write port fills shapes under a sequencer, one cell per cycle
// while walking a row span. Unknown commands, pixels off the canvas and label or off-canvas
// reads go straight to the result stage; a stored-cell read passes the RAM read register first.
// A shape visits its rows one by one and writes each cell of a span; clear writes every cell.
// One item is in work at a time.
// Reset and every size register write run a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells.
module char_canvas_shape_fill #(
  parameter int MAX_WIDTH  = ccsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ccsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration write port.
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ccsf_pkg::DIM_W-1:0]  cfg_data,
  // Command channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic signed [7:0]           in_pos_x,
  input  logic signed [7:0]           in_pos_y,
  input  logic [6:0]                  in_size_w,
  input  logic [6:0]                  in_size_h,
  input  logic [7:0]                  in_brush,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [7:0]                  out_cell_char
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = ccsf_pkg::DIM_W;
  localparam int CW    = ccsf_pkg::COORD_W;
  localparam int KW    = ccsf_pkg::ROWK_W;
  localparam logic [DW-1:0] WMAX = DW'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
  localparam logic [DW-1:0] HMAX = DW'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);
  localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] ZERO = CW'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_RDW,
    ST_CLR,
    ST_DONE
  } state_t;

  // Size register write: zero becomes one, values above the storage size saturate.
  function automatic logic [DW-1:0] clamp_size(input logic [DW-1:0] v,
                                               input logic [DW-1:0] maxv);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // RAM address of a 1-based canvas cell.
  function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] row,
                                              input logic [DW-1:0] col);
    logic [DW-1:0] rz;
    logic [DW-1:0] cz;
    rz = row - DW'(1);
    cz = col - DW'(1);
    return AW'(rz) * MW_A + AW'(cz);
  endfunction

  // Label digit '0' + ((i-1) mod 10); the quotient comes from a reciprocal multiply.
  function automatic logic [7:0] label_of(input logic [DW-1:0] i);
    logic [DW-1:0] v;
    logic [14:0]   prod;
    logic [3:0]    q;
    logic [DW-1:0] dig;
    v    = i - DW'(1);
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    dig  = v - DW'(q) * DW'(10);
    return ccsf_pkg::CHAR_ZERO + 8'(dig[3:0]);
  endfunction

  state_t            state_r, state_nxt;
  logic [DW-1:0]     width_r, width_nxt;
  logic [DW-1:0]     height_r, height_nxt;
  ccsf_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [7:0]        y_r, y_nxt;
  logic [6:0]        w_r, w_nxt;
  logic [6:0]        h_r, h_nxt;
  logic [7:0]        brush_r, brush_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     n_r, n_nxt;
  logic [DW-1:0]     row_r, row_nxt;
  logic [DW-1:0]     col_r, col_nxt;
  logic [DW-1:0]     col_end_r, col_end_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              clr_res_r, clr_res_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [7:0]        res_char_r, res_char_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [7:0]        out_char_r, out_char_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  ccsf_pkg::cmd_t    in_cmd;
  logic              accept;
  logic signed [CW-1:0] wext, hext;
  logic signed [CW-1:0] ix, iy;
  logic              pix_in, rd_in;

  logic signed [CW-1:0] xs, ys, ks, hs, ws;
  logic signed [CW-1:0] dk, absd, hw;
  logic signed [CW-1:0] rrow, lo, hi, lo_c, hi_c;
  logic              row_hit;
  logic [KW-1:0]     k_inc;

  assign in_cmd   = ccsf_pkg::cmd_t'(in_command);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Bounds checks of the incoming position against the canvas size.
  assign wext   = CW'(width_r);
  assign hext   = CW'(height_r);
  assign ix     = {{(CW-8){in_pos_x[7]}}, in_pos_x};
  assign iy     = {{(CW-8){in_pos_y[7]}}, in_pos_y};
  assign pix_in = (ix >= ONE) && (ix <= wext) && (iy >= ONE) && (iy <= hext);
  assign rd_in  = (ix >= ZERO) && (ix <= wext) && (iy >= ZERO) && (iy <= hext);

  // Span of shape row k: row number and unclipped column range.
  assign xs    = {{(CW-8){x_r[7]}}, x_r};
  assign ys    = {{(CW-8){y_r[7]}}, y_r};
  assign ks    = CW'(k_r);
  assign hs    = CW'(h_r);
  assign ws    = CW'(w_r);
  assign dk    = ks - hs;
  assign absd  = dk[CW-1] ? -dk : dk;
  assign hw    = hs - absd;
  assign k_inc = k_r + KW'(1);

  always_comb begin
    rrow = ys;
    lo   = xs;
    hi   = xs;
    unique case (cmd_r)
      ccsf_pkg::CMD_RECT: begin
        rrow = ys + ONE + ks;
        lo   = xs + ONE;
        hi   = xs + ws;
      end
      ccsf_pkg::CMD_UP: begin
        rrow = ys + ONE + ks;
        lo   = xs + ONE - ks;
        hi   = xs + ONE + ks;
      end
      ccsf_pkg::CMD_DOWN: begin
        rrow = ys + ONE - ks;
        lo   = xs + ONE - ks;
        hi   = xs + ONE + ks;
      end
      ccsf_pkg::CMD_DIAM: begin
        rrow = ys + ONE + ks;
        lo   = xs + ONE - hw;
        hi   = xs + ONE + hw;
      end
      default: begin
        rrow = ys;
        lo   = xs;
        hi   = xs;
      end
    endcase
  end

  // Clip the span to the drawable area.
  assign lo_c    = (lo < ONE) ? ONE : lo;
  assign hi_c    = (hi > wext) ? wext : hi;
  assign row_hit = (rrow >= ONE) && (rrow <= hext) && (lo_c <= hi_c);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    cmd_nxt       = cmd_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    brush_nxt     = brush_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    col_end_nxt   = col_end_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_res_nxt   = clr_res_r;
    res_ok_nxt    = res_ok_r;
    res_char_nxt  = res_char_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_char_nxt  = out_char_r;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr(row_r, col_r);
    ram_wdata     = brush_r;
    ram_re        = 1'b0;

    // The result register empties when the consumer takes the beat.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_cmd;
          x_nxt        = in_pos_x;
          y_nxt        = in_pos_y;
          w_nxt        = in_size_w;
          h_nxt        = in_size_h;
          brush_nxt    = in_brush;
          k_nxt        = '0;
          n_nxt        = '0;
          res_ok_nxt   = 1'b1;
          res_char_nxt = '0;
          state_nxt    = ST_DONE;
          unique case (in_cmd)
            ccsf_pkg::CMD_PIXEL: begin
              res_ok_nxt = pix_in;
              n_nxt      = KW'(1);
              if (pix_in) begin
                state_nxt = ST_ROW;
              end
            end
            ccsf_pkg::CMD_RECT: begin
              n_nxt = KW'(in_size_h);
              if (in_size_w != '0 && in_size_h != '0) begin
                state_nxt = ST_ROW;
              end
            end
            ccsf_pkg::CMD_UP, ccsf_pkg::CMD_DOWN: begin
              n_nxt = KW'(in_size_h);
              if (in_size_h != '0) begin
                state_nxt = ST_ROW;
              end
            end
            ccsf_pkg::CMD_DIAM: begin
              n_nxt     = {1'b0, in_size_h, 1'b1};
              state_nxt = ST_ROW;
            end
            ccsf_pkg::CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_res_nxt = 1'b1;
              state_nxt   = ST_CLR;
            end
            ccsf_pkg::CMD_READ: begin
              if (!rd_in) begin
                res_ok_nxt = 1'b0;
              end else if (ix == ZERO && iy == ZERO) begin
                res_char_nxt = ccsf_pkg::CHAR_SPACE;
              end else if (iy == ZERO) begin
                res_char_nxt = label_of(in_pos_x[DW-1:0]);
              end else if (ix == ZERO) begin
                res_char_nxt = label_of(in_pos_y[DW-1:0]);
              end else begin
                state_nxt = ST_RDW;
              end
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end
      end

      // Find the next shape row that touches the canvas.
      ST_ROW: begin
        if (row_hit) begin
          row_nxt     = rrow[DW-1:0];
          col_nxt     = lo_c[DW-1:0];
          col_end_nxt = hi_c[DW-1:0];
          state_nxt   = ST_COL;
        end else begin
          k_nxt = k_inc;
          if (k_inc == n_r) begin
            state_nxt = ST_DONE;
          end
        end
      end

      // Write one cell of the current span.
      ST_COL: begin
        ram_we = 1'b1;
        if (col_r == col_end_r) begin
          k_nxt     = k_inc;
          state_nxt = (k_inc == n_r) ? ST_DONE : ST_ROW;
        end else begin
          col_nxt = col_r + DW'(1);
        end
      end

      // Stored cell arrives from the RAM read register.
      ST_RDW: begin
        res_char_nxt = ram_rdata;
        state_nxt    = ST_DONE;
      end

      // Clearing pass over the whole RAM.
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = ccsf_pkg::CHAR_BLANK;
        if (clr_cnt_r == LAST) begin
          state_nxt = clr_res_r ? ST_DONE : ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_char_nxt  = res_char_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Read issue for every accepted read command; only a stored-cell read uses the data.
    if (accept && in_cmd == ccsf_pkg::CMD_READ) begin
      ram_re = 1'b1;
    end

    // A size write resizes and starts a clearing pass.
    if (cfg_we) begin
      unique case (cfg_index)
        ccsf_pkg::CFG_WIDTH:  width_nxt  = clamp_size(cfg_data, WMAX);
        ccsf_pkg::CFG_HEIGHT: height_nxt = clamp_size(cfg_data, HMAX);
        default:              width_nxt  = width_r;
      endcase
      clr_cnt_nxt = '0;
      clr_res_nxt = 1'b0;
      state_nxt   = ST_CLR;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      width_r     <= clamp_size(ccsf_pkg::SIZE_RESET, WMAX);
      height_r    <= clamp_size(ccsf_pkg::SIZE_RESET, HMAX);
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    brush_r    <= brush_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    col_end_r  <= col_end_nxt;
    res_ok_r   <= res_ok_nxt;
    res_char_r <= res_char_nxt;
    out_ok_r   <= out_ok_nxt;
    out_char_r <= out_char_nxt;
  end

  ccsf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(cell_addr(in_pos_y[DW-1:0], in_pos_x[DW-1:0])),
    .rdata(ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_cell_char = out_char_r;

`ifndef SYNTHESIS
  // Shape writes only land inside the drawable area.
  a_col_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COL |-> row_r >= DW'(1) && row_r <= height_r &&
                          col_r >= DW'(1) && col_r <= width_r)
    else $error("shape write outside the canvas");

  // The column walk never passes the end of its span.
  a_col_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COL |-> col_r <= col_end_r)
    else $error("column walk passed the span end");

  // The row counter stays below the shape's row count.
  a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROW |-> k_r < n_r)
    else $error("row counter overran the shape");

  // An accepted beat always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted command did not start");

  // A character is only returned together with ok.
  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_char != 8'd0 |-> out_ok)
    else $error("character returned without ok");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for char_canvas_shape_fill with an in-line canvas predictor.
module tb;

  localparam int COLS              = ccsf_pkg::MAX_WIDTH_DEF;
  localparam int ROWS              = ccsf_pkg::MAX_HEIGHT_DEF;
  localparam int CLEAR_PASS_CYCLES = COLS * ROWS;
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES      = 64;
  localparam int CYCLE_LIMIT       = 4000000;
  // The one 3-bit code with no operation behind it.
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  typedef struct {
    logic [2:0]        command;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [6:0]        size_w;
    logic [6:0]        size_h;
    logic [7:0]        brush;
  } canvas_cmd_t;

  typedef struct {
    logic       ok;
    logic [7:0] cell_char;
  } canvas_reply_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic              cfg_index     = ccsf_pkg::CFG_WIDTH;
  logic [ccsf_pkg::DIM_W-1:0] cfg_data = '0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [2:0]        in_command    = '0;
  logic signed [7:0] in_pos_x      = '0;
  logic signed [7:0] in_pos_y      = '0;
  logic [6:0]        in_size_w     = '0;
  logic [6:0]        in_size_h     = '0;
  logic [7:0]        in_brush      = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic              out_ok;
  logic [7:0]        out_cell_char;

  // Predicted canvas contents and size, kept in step with accepted commands.
  logic [7:0]    canvas_cells [COLS*ROWS];
  int            canvas_w = COLS;
  int            canvas_h = ROWS;
  canvas_reply_t canvas_replies [$];

  int failures      = 0;
  int cycle_count   = 0;
  bit sender_idles  = 1'b1;
  bit receiver_idles = 1'b1;
  bit long_hold_req = 1'b0;

  char_canvas_shape_fill u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_size_w     (in_size_w),
    .in_size_h     (in_size_h),
    .in_brush      (in_brush),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_cell_char (out_cell_char)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void blank_canvas();
    foreach (canvas_cells[i]) canvas_cells[i] = ccsf_pkg::CHAR_BLANK;
  endfunction

  // Paint one row segment, clipped to the drawable area.
  function automatic void fill_row(int row, int lo, int hi, logic [7:0] b);
    int col;
    if (row < 1 || row > canvas_h) return;
    if (lo < 1) lo = 1;
    if (hi > canvas_w) hi = canvas_w;
    for (col = lo; col <= hi; col++) canvas_cells[(row - 1) * COLS + col - 1] = b;
  endfunction

  function automatic logic [7:0] label_char(int i);
    return ccsf_pkg::CHAR_ZERO + 8'((i - 1) % 10);
  endfunction

  function automatic int clamp_dim(logic [6:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Update the canvas for one command and work out the reply it should give.
  function automatic canvas_reply_t apply_canvas_command(canvas_cmd_t c);
    canvas_reply_t rep;
    int x, y, w, h, r, d, hw;
    x = c.pos_x;
    y = c.pos_y;
    w = c.size_w;
    h = c.size_h;
    rep.ok = 1'b1;
    rep.cell_char = 8'd0;
    case (c.command)
      ccsf_pkg::CMD_PIXEL: begin
        if (x >= 1 && x <= canvas_w && y >= 1 && y <= canvas_h)
          canvas_cells[(y - 1) * COLS + x - 1] = c.brush;
        else
          rep.ok = 1'b0;
      end
      ccsf_pkg::CMD_RECT: begin
        if (w > 0)
          for (r = y + 1; r <= y + h; r++) fill_row(r, x + 1, x + w, c.brush);
      end
      ccsf_pkg::CMD_UP: begin
        for (r = 0; r < h; r++) fill_row(y + 1 + r, x + 1 - r, x + 1 + r, c.brush);
      end
      ccsf_pkg::CMD_DOWN: begin
        for (r = 0; r < h; r++) fill_row(y + 1 - r, x + 1 - r, x + 1 + r, c.brush);
      end
      ccsf_pkg::CMD_DIAM: begin
        for (r = 0; r <= 2 * h; r++) begin
          d = r - h;
          hw = h - (d < 0 ? -d : d);
          fill_row(y + 1 + r, x + 1 - hw, x + 1 + hw, c.brush);
        end
      end
      ccsf_pkg::CMD_CLEAR: blank_canvas();
      ccsf_pkg::CMD_READ: begin
        // Row 0 and column 0 are labels; the corner is a space.
        if (x < 0 || x > canvas_w || y < 0 || y > canvas_h) rep.ok = 1'b0;
        else if (x == 0 && y == 0) rep.cell_char = ccsf_pkg::CHAR_SPACE;
        else if (y == 0) rep.cell_char = label_char(x);
        else if (x == 0) rep.cell_char = label_char(y);
        else rep.cell_char = canvas_cells[(y - 1) * COLS + x - 1];
      end
      default: rep.ok = 1'b0;
    endcase
    return rep;
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinates mostly land on the canvas or just past its edges, sometimes anywhere.
  function automatic logic signed [7:0] pick_coord(int extent);
    int v;
    if ($urandom_range(0, 99) < 85) v = int'($urandom_range(0, extent + 3)) - 2;
    else v = $urandom_range(0, 255);
    return 8'(v);
  endfunction

  function automatic logic [6:0] pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 7'($urandom_range(0, 8));
    if (p < 95) return 7'($urandom_range(0, 40));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic canvas_cmd_t cmd_of(logic [2:0] op, int x, int y, int w, int h, int b);
    canvas_cmd_t c;
    c.command = op;
    c.pos_x = 8'(x);
    c.pos_y = 8'(y);
    c.size_w = 7'(w);
    c.size_h = 7'(h);
    c.brush = 8'(b);
    return c;
  endfunction

  // Reads are frequent so that drawn cells get observed; clears are rare since they are slow.
  function automatic canvas_cmd_t make_random_command();
    canvas_cmd_t c;
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) c.command = ccsf_pkg::CMD_READ;
    else if (p < 45) c.command = ccsf_pkg::CMD_PIXEL;
    else if (p < 60) c.command = ccsf_pkg::CMD_RECT;
    else if (p < 70) c.command = ccsf_pkg::CMD_UP;
    else if (p < 80) c.command = ccsf_pkg::CMD_DOWN;
    else if (p < 93) c.command = ccsf_pkg::CMD_DIAM;
    else if (p < 96) c.command = ccsf_pkg::CMD_CLEAR;
    else c.command = CMD_UNKNOWN;
    c.pos_x = pick_coord(canvas_w);
    c.pos_y = pick_coord(canvas_h);
    c.size_w = pick_size();
    c.size_h = pick_size();
    c.brush = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Offer one command beat, wait for it to be taken, then record its predicted reply.
  task automatic issue_command(canvas_cmd_t c);
    int gap;
    gap = sender_idles ? pick_idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= c.command;
    in_pos_x   <= c.pos_x;
    in_pos_y   <= c.pos_y;
    in_size_w  <= c.size_w;
    in_size_h  <= c.size_h;
    in_brush   <= c.brush;
    do @(posedge clk); while (in_ready !== 1'b1);
    canvas_replies.push_back(apply_canvas_command(c));
  endtask

  task automatic random_burst(int n);
    repeat (n) issue_command(make_random_command());
  endtask

  // Stop offering commands and wait until every reply is back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (canvas_replies.size() == 0);
  endtask

  // Size writes happen only with the block idle. It may still be finishing a command or a
  // clearing pass from reset or an earlier write, so a full pass is waited out first.
  task automatic write_size(logic idx, logic [6:0] value);
    settle();
    repeat (CLEAR_PASS_CYCLES + 16) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == ccsf_pkg::CFG_WIDTH) canvas_w = clamp_dim(value, COLS);
    else canvas_h = clamp_dim(value, ROWS);
    blank_canvas();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        stall = receiver_idles ? pick_idle_len() : 0;
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Compare each result beat with the oldest predicted reply.
  always @(posedge clk) begin
    canvas_reply_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (canvas_replies.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing outstanding, ok %0b char %0d",
                 $time, out_ok, out_cell_char);
      end else begin
        want = canvas_replies.pop_front();
        if (out_ok !== want.ok) begin
          failures++;
          $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, out_ok);
        end
        if (out_cell_char !== want.cell_char) begin
          failures++;
          $display("%0t: cell_char mismatch, expected %0d, actual %0d",
                   $time, want.cell_char, out_cell_char);
        end
      end
    end
  end

  // Label row and column, the corner, and reads just off the canvas.
  task automatic test_labels();
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 0, 0, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 1, 0, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 11, 0, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 64, 0, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 0, 64, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 65, 3, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 3, -1, 0, 0, 0));
  endtask

  // Pixels at the corners of the canvas and outside it, with extreme brushes.
  task automatic test_pixels();
    issue_command(cmd_of(ccsf_pkg::CMD_PIXEL, 1, 1, 0, 0, 8'h41));
    issue_command(cmd_of(ccsf_pkg::CMD_PIXEL, 64, 64, 127, 127, 255));
    issue_command(cmd_of(ccsf_pkg::CMD_PIXEL, 0, 5, 0, 0, 8'h78));
    issue_command(cmd_of(ccsf_pkg::CMD_PIXEL, -128, 127, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 64, 64, 0, 0, 0));
  endtask

  // Each shape, zero sizes, the largest diamond, the unused code and a clear.
  task automatic test_shapes();
    issue_command(cmd_of(ccsf_pkg::CMD_RECT, 0, 0, 0, 5, 8'h2a));
    issue_command(cmd_of(ccsf_pkg::CMD_RECT, 0, 0, 5, 0, 8'h2a));
    issue_command(cmd_of(ccsf_pkg::CMD_RECT, 2, 2, 3, 2, 8'h23));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 4, 3, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_UP, 10, 10, 0, 0, 8'h75));
    issue_command(cmd_of(ccsf_pkg::CMD_UP, 10, 10, 0, 3, 8'h75));
    issue_command(cmd_of(ccsf_pkg::CMD_DOWN, 20, 20, 0, 3, 8'h64));
    issue_command(cmd_of(ccsf_pkg::CMD_DIAM, 30, 30, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 31, 31, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_DIAM, 40, -100, 0, 127, 255));
    issue_command(cmd_of(CMD_UNKNOWN, 5, 5, 5, 5, 8'h3f));
    issue_command(cmd_of(ccsf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
    issue_command(cmd_of(ccsf_pkg::CMD_READ, 1, 1, 0, 0, 0));
  endtask

  // Zero written to both sizes gives a one-cell canvas.
  task automatic test_tiny_canvas();
    write_size(ccsf_pkg::CFG_WIDTH, 7'd0);
    write_size(ccsf_pkg::CFG_HEIGHT, 7'd0);
    random_burst(15);
  endtask

  // Oversized width saturates; a short canvas below it.
  task automatic test_size_saturation();
    write_size(ccsf_pkg::CFG_WIDTH, 7'd127);
    write_size(ccsf_pkg::CFG_HEIGHT, 7'd7);
    random_burst(20);
  endtask

  task automatic test_tall_canvas();
    write_size(ccsf_pkg::CFG_WIDTH, 7'd1);
    write_size(ccsf_pkg::CFG_HEIGHT, 7'd64);
    random_burst(20);
  endtask

  // Hold the result side off for a long stretch while commands keep coming.
  task automatic test_backpressure();
    write_size(ccsf_pkg::CFG_WIDTH, 7'($urandom_range(2, 63)));
    write_size(ccsf_pkg::CFG_HEIGHT, 7'($urandom_range(2, 63)));
    random_burst(15);
    settle();
    long_hold_req = 1'b1;
    sender_idles = 1'b0;
    random_burst(10);
    sender_idles = 1'b1;
  endtask

  // A stretch with no idling on either side, then a mixed run.
  task automatic test_random_mix();
    write_size(ccsf_pkg::CFG_WIDTH, 7'd65);
    write_size(ccsf_pkg::CFG_HEIGHT, 7'd127);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    random_burst(20);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    random_burst(20);
  endtask

  initial begin
    blank_canvas();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_labels();
    test_pixels();
    test_shapes();
    test_tiny_canvas();
    test_size_saturation();
    test_tall_canvas();
    test_backpressure();
    test_random_mix();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> char_canvas_shape_fill.f
src/ccsf_pkg.sv
src/ccsf_ram.sv
src/char_canvas_shape_fill.sv
tb/sv/tb.sv
